FILE: hw/rtl/mtg_pkg.sv
// mtg_pkg: constants, sequencer state type and tempering function of the
// mt19937 word generator; no dependencies, used by the top level

package mtg_pkg;

   localparam int          STATE_DEPTH_DEF = 624;
   localparam int          TWIST_SHIFT     = 397;
   localparam int          WORD_W          = 32;

   localparam logic [31:0] TWIST_MATRIX    = 32'h9908b0df;
   localparam logic [31:0] SEED_MULT       = 32'd1812433253;
   localparam logic [31:0] TEMPER_B        = 32'h9d2c5680;
   localparam logic [31:0] TEMPER_C        = 32'hefc60000;

   localparam logic        MODE_SEED       = 1'b0;
   localparam logic        MODE_NEXT       = 1'b1;

   typedef enum logic [2:0] {
      MTG_IDLE,
      MTG_SEED_MUL,
      MTG_SEED_WR,
      MTG_TW_CUR,
      MTG_TW_RD,
      MTG_TW_WR,
      MTG_OUT_RD,
      MTG_OUT_TMP
   } mtg_state_type;

   function automatic logic [31:0] mtg_temper(input logic [31:0] y_in);
      logic [31:0] y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

FILE: hw/rtl/mtg_ram.sv
// mtg_ram: generic single-write, dual-read memory with registered read data
// no dependencies

module mtg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: hw/rtl/mersenne_twister_generator_unit.sv
// mersenne_twister_generator_unit: mt19937 32-bit generator, sequencer around
// one state memory; depends on mtg_pkg and mtg_ram
//
// Usage
//   req channel: req_mode = 0 seeds the state from req_seed_value, req_mode = 1
//   asks for the next tempered word. One transaction at a time: req_ready is
//   high only while the sequencer is idle.
//   rsp channel: one transaction per next command, none per seed command. The
//   result sits in an output register, so a new request is taken while an
//   earlier word still waits on rsp_ready.
//   Seed: the block stays busy with one multiply step and one write step
//   per state word. Next: the word passes the read and tempering steps
//   into the output register; when the state is used up the block first
//   regenerates it (an extra read of word zero, then two memory reads and
//   one write per word, in a read step and a write step).
//   Reset: the state memory is not cleared; the read index says regeneration
//   is needed. Words drawn before the first seed are undefined.
//   Stall: if rsp_ready stays low, the next word waits in the sequencer until
//   the output register frees up.

module mersenne_twister_generator_unit
   import mtg_pkg::*;
#(
   parameter int STATE_DEPTH = STATE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_random_word
);

   localparam int AW = $clog2(STATE_DEPTH);
   localparam int IW = $clog2(STATE_DEPTH + 1);

   mtg_state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [AW-1:0] k_ff, k_in;
   logic [31:0]   cur_ff, cur_in;
   logic [31:0]   prev_ff, prev_in;
   logic [31:0]   prod_ff, prod_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_word_ff, rsp_word_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic [31:0]   rd_data_a, rd_data_b;

   logic [AW-1:0] nxt_addr, far_addr;
   logic [AW:0]   far_sum;
   logic [31:0]   seed_x, seed_word;
   logic [31:0]   twist_y, twist_w;
   logic          slot_free;
   logic          last_k;

   mtg_ram #(
      .WIDTH(WORD_W),
      .DEPTH(STATE_DEPTH)
   ) u_state_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_data_a(rd_data_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_b(rd_data_b)
   );

   // neighbor and far addresses of the twist, wrapping at the depth
   assign last_k   = (k_ff == AW'(STATE_DEPTH - 1));
   assign nxt_addr = last_k ? '0 : k_ff + 1'b1;
   assign far_sum  = {1'b0, k_ff} + (AW+1)'(TWIST_SHIFT);
   assign far_addr = (far_sum >= (AW+1)'(STATE_DEPTH)) ?
                     AW'(far_sum - (AW+1)'(STATE_DEPTH)) : far_sum[AW-1:0];

   assign seed_x    = prev_ff ^ (prev_ff >> 30);
   assign seed_word = prod_ff + {{(32-AW){1'b0}}, k_ff};

   assign twist_y = {cur_ff[31], rd_data_a[30:0]};
   assign twist_w = rd_data_b ^ {1'b0, twist_y[31:1]} ^
                    (twist_y[0] ? TWIST_MATRIX : 32'h0);

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prod_in      = prod_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = k_ff;
      wr_data      = seed_word;
      rd_addr_a    = idx_ff[AW-1:0];
      rd_addr_b    = far_addr;
      req_ready    = 1'b0;

      case (state_ff)
         MTG_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_SEED) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = req_seed_value;
                  prev_in  = req_seed_value;
                  k_in     = AW'(1);
                  state_in = MTG_SEED_MUL;
               end else if (idx_ff == IW'(STATE_DEPTH)) begin
                  k_in     = '0;
                  state_in = MTG_TW_CUR;
               end else begin
                  state_in = MTG_OUT_RD;
               end
            end
         end
         MTG_SEED_MUL: begin
            prod_in  = seed_x * SEED_MULT;
            state_in = MTG_SEED_WR;
         end
         MTG_SEED_WR: begin
            wr_en   = 1'b1;
            prev_in = seed_word;
            if (last_k) begin
               idx_in   = IW'(STATE_DEPTH);
               state_in = MTG_IDLE;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = MTG_SEED_MUL;
            end
         end
         MTG_TW_CUR: begin
            rd_addr_a = '0;
            state_in  = MTG_TW_RD;
         end
         MTG_TW_RD: begin
            // word zero arrives from the extra read issued on entry
            if (k_ff == '0) begin
               cur_in = rd_data_a;
            end
            rd_addr_a = nxt_addr;
            rd_addr_b = far_addr;
            state_in  = MTG_TW_WR;
         end
         MTG_TW_WR: begin
            wr_en   = 1'b1;
            wr_data = twist_w;
            cur_in  = rd_data_a;
            if (last_k) begin
               idx_in   = '0;
               state_in = MTG_OUT_RD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = MTG_TW_RD;
            end
         end
         MTG_OUT_RD: begin
            state_in = MTG_OUT_TMP;
         end
         MTG_OUT_TMP: begin
            if (slot_free) begin
               rsp_word_in  = mtg_temper(rd_data_a);
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
               state_in     = MTG_IDLE;
            end
         end
         default: begin
            state_in = MTG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= MTG_IDLE;
         idx_ff       <= IW'(STATE_DEPTH);
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      prod_ff     <= prod_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   // a new word only ever comes out of the tempering step
   a_rsp_from_temper: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == MTG_OUT_TMP))
      else $error("rsp_valid rose outside the output step");

   // read index never passes the regeneration mark
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IW'(STATE_DEPTH))
      else $error("read index beyond state depth");

   // a finished twist always hands index zero to the output read
   a_twist_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MTG_TW_WR && last_k) |=> (idx_ff == '0 && state_ff == MTG_OUT_RD))
      else $error("twist did not end at index zero");

   // an unconsumed word is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_word_ff)))
      else $error("pending word lost or changed");

endmodule
